### hdl/rtpq_pkg.sv
package rtpq_pkg;

  localparam int unsigned Depth = 64;
  localparam int unsigned IdxW  = $clog2(Depth);
  // Logical indexes and the occupancy both fit in one extra bit.
  localparam int unsigned LogW  = IdxW + 1;

  localparam logic [31:0] HalfRange = 32'h7FFF_FFFF;
  localparam logic [7:0]  CountMax  = 8'hFF;

  localparam logic ReqAdd = 1'b0;
  localparam logic ReqPop = 1'b1;

  localparam logic [2:0] StNew   = 3'd0;
  localparam logic [2:0] StJoin  = 3'd1;
  localparam logic [2:0] StLate  = 3'd2;
  localparam logic [2:0] StFull  = 3'd3;
  localparam logic [2:0] StPop   = 3'd4;
  localparam logic [2:0] StEmpty = 3'd5;

  typedef struct packed {
    logic [31:0] ts;
    logic [31:0] play;
    logic [7:0]  cnt;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

### hdl/rtpq_ram.sv
module rtpq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Words = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Words)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Words)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Words];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/rtp_playout_queue_unit.sv
// Channel   Direction  Handshake          Payload
// request   in         start_i / busy_o   req_type_i, rtp_ts_i, playout_ms_i, now_ms_i
// result    out        done_o (strobe)    status_o, late_ms_o, out_timestamp_o,
//                                         out_playout_ms_o, out_packet_count_o, late_total_o
//
// A request is taken when start_i is high and busy_o is low; exactly one result
// follows, shown for one cycle with done_o, and busy_o drops in that same cycle.
// A pop reads the head group, and an add to an empty table writes at once. Any
// other add reads the head and then searches the N stored groups from the tail;
// an insertion then moves the M groups at and behind the insertion place back one
// by one (none at the tail) before the new group is written. The single read port
// of the group memory sets this pace.
// Reset clears the occupancy, head pointer and late counter at once; the
// memory itself is never cleared. The receiver cannot stall results.
module rtp_playout_queue_unit
  import rtpq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        req_type_i,
  input  logic [31:0] rtp_ts_i,
  input  logic [31:0] playout_ms_i,
  input  logic [31:0] now_ms_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [31:0] late_ms_o,
  output logic [31:0] out_timestamp_o,
  output logic [31:0] out_playout_ms_o,
  output logic [7:0]  out_packet_count_o,
  output logic [31:0] late_total_o
);

  // Sequencer states.
  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SPop    = 3'd1;
  localparam logic [2:0] SHead   = 3'd2;
  localparam logic [2:0] SScan   = 3'd3;
  localparam logic [2:0] SDecide = 3'd4;
  localparam logic [2:0] SShift  = 3'd5;
  localparam logic [2:0] SPut    = 3'd6;

  // The table is a ring in memory: logical index 0 is the head group, so a pop
  // only moves the head pointer. This maps a logical index to a memory address.
  function automatic logic [IdxW-1:0] phys(input logic [IdxW-1:0] head,
                                           input logic [LogW-1:0] idx);
    logic [LogW-1:0] sum;
    sum = {1'b0, head} + idx;
    if (sum >= LogW'(Depth)) begin
      sum = sum - LogW'(Depth);
    end
    return sum[IdxW-1:0];
  endfunction

  logic [2:0]      state_q, state_d;
  logic [IdxW-1:0] head_q, head_d;
  logic [LogW-1:0] occ_q, occ_d;
  logic [31:0]     late_cnt_q, late_cnt_d;

  // The request being worked on.
  logic [31:0]     ts_q, ts_d;
  logic [31:0]     play_q, play_d;
  logic [31:0]     now_q, now_d;

  // Search and move bookkeeping: iss_* issues reads, pv/pidx track the read in
  // flight whose data arrives in the current cycle.
  logic            wrapped_q, wrapped_d;
  logic [LogW-1:0] iss_q, iss_d;
  logic            iss_act_q, iss_act_d;
  logic            pv_q, pv_d;
  logic [LogW-1:0] pidx_q, pidx_d;
  logic            match_q, match_d;
  logic [LogW-1:0] midx_q, midx_d;
  entry_t          mdata_q, mdata_d;
  logic            found_q, found_d;
  logic [LogW-1:0] pos_q, pos_d;

  // Result registers.
  logic            done_q, done_d;
  logic [2:0]      status_q, status_d;
  logic [31:0]     late_ms_q, late_ms_d;
  logic [31:0]     ots_q, ots_d;
  logic [31:0]     oplay_q, oplay_d;
  logic [7:0]      ocnt_q, ocnt_d;

  // Memory port.
  logic            ram_we, ram_re;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  entry_t          ram_wdata, ram_rdata;
  logic [EntryW-1:0] ram_rword;

  logic [31:0]     ts_diff;
  logic            hit;

  assign ram_rdata = entry_t'(ram_rword);
  assign ts_diff   = ram_rdata.ts - ts_q;
  assign hit       = wrapped_q ? (ts_diff > HalfRange) : (ram_rdata.ts < ts_q);

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    occ_d      = occ_q;
    late_cnt_d = late_cnt_q;
    ts_d       = ts_q;
    play_d     = play_q;
    now_d      = now_q;
    wrapped_d  = wrapped_q;
    iss_d      = iss_q;
    iss_act_d  = iss_act_q;
    pv_d       = 1'b0;
    pidx_d     = pidx_q;
    match_d    = match_q;
    midx_d     = midx_q;
    mdata_d    = mdata_q;
    found_d    = found_q;
    pos_d      = pos_q;
    done_d     = 1'b0;
    status_d   = status_q;
    late_ms_d  = late_ms_q;
    ots_d      = ots_q;
    oplay_d    = oplay_q;
    ocnt_d     = ocnt_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = '0;
    ram_raddr  = '0;
    ram_wdata  = '0;

    unique case (state_q)
      SIdle: begin
        if (start_i) begin
          ts_d      = rtp_ts_i;
          play_d    = playout_ms_i;
          now_d     = now_ms_i;
          late_ms_d = '0;
          ots_d     = '0;
          oplay_d   = '0;
          ocnt_d    = '0;
          match_d   = 1'b0;
          found_d   = 1'b0;
          pos_d     = '0;
          if (req_type_i == ReqPop) begin
            if (occ_q == '0) begin
              status_d = StEmpty;
              done_d   = 1'b1;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = phys(head_q, '0);
              state_d   = SPop;
            end
          end else if (occ_q == '0) begin
            // Empty table: the group goes in at once, no lateness check.
            ram_we    = 1'b1;
            ram_waddr = phys(head_q, '0);
            ram_wdata = '{ts: rtp_ts_i, play: playout_ms_i, cnt: 8'd1};
            occ_d     = LogW'(1);
            status_d  = StNew;
            done_d    = 1'b1;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = phys(head_q, '0);
            state_d   = SHead;
          end
        end
      end

      SPop: begin
        ots_d    = ram_rdata.ts;
        oplay_d  = ram_rdata.play;
        ocnt_d   = ram_rdata.cnt;
        head_d   = phys(head_q, LogW'(1));
        occ_d    = occ_q - LogW'(1);
        status_d = StPop;
        done_d   = 1'b1;
        state_d  = SIdle;
      end

      SHead: begin
        // Serial-number ordering applies when the new timestamp lies at least HalfRange
        // below the timestamp of the head group.
        wrapped_d = (ts_q < ram_rdata.ts) && ((ram_rdata.ts - ts_q) >= HalfRange);
        ram_re    = 1'b1;
        ram_raddr = phys(head_q, occ_q - LogW'(1));
        pv_d      = 1'b1;
        pidx_d    = occ_q - LogW'(1);
        iss_act_d = (occ_q != LogW'(1));
        iss_d     = occ_q - LogW'(2);
        state_d   = SScan;
      end

      SScan: begin
        // Walk from the tail toward the head: the last match seen is the one
        // nearest the head, the first hit marks the insertion place.
        if (iss_act_q) begin
          ram_re    = 1'b1;
          ram_raddr = phys(head_q, iss_q);
          pv_d      = 1'b1;
          pidx_d    = iss_q;
          iss_act_d = (iss_q != '0);
          iss_d     = iss_q - LogW'(1);
        end
        if (pv_q) begin
          if (ram_rdata.ts == ts_q) begin
            match_d = 1'b1;
            midx_d  = pidx_q;
            mdata_d = ram_rdata;
          end
          if (hit && !found_q) begin
            found_d = 1'b1;
            pos_d   = pidx_q + LogW'(1);
          end
          if (pidx_q == '0) begin
            state_d = SDecide;
          end
        end
      end

      SDecide: begin
        if (match_q) begin
          ram_we    = 1'b1;
          ram_waddr = phys(head_q, midx_q);
          ram_wdata = mdata_q;
          if (mdata_q.cnt != CountMax) begin
            ram_wdata.cnt = mdata_q.cnt + 8'd1;
          end
          status_d = StJoin;
          done_d   = 1'b1;
          state_d  = SIdle;
        end else if (play_q < now_q) begin
          late_ms_d  = now_q - play_q;
          late_cnt_d = late_cnt_q + 32'd1;
          status_d   = StLate;
          done_d     = 1'b1;
          state_d    = SIdle;
        end else if (occ_q >= LogW'(Depth)) begin
          status_d = StFull;
          done_d   = 1'b1;
          state_d  = SIdle;
        end else if (pos_q == occ_q) begin
          state_d = SPut;
        end else begin
          // Move the groups at and behind the insertion place one step back,
          // starting from the tail.
          ram_re    = 1'b1;
          ram_raddr = phys(head_q, occ_q - LogW'(1));
          pv_d      = 1'b1;
          pidx_d    = occ_q - LogW'(1);
          iss_act_d = ((occ_q - LogW'(1)) != pos_q);
          iss_d     = occ_q - LogW'(2);
          state_d   = SShift;
        end
      end

      SShift: begin
        if (iss_act_q) begin
          ram_re    = 1'b1;
          ram_raddr = phys(head_q, iss_q);
          pv_d      = 1'b1;
          pidx_d    = iss_q;
          iss_act_d = (iss_q != pos_q);
          iss_d     = iss_q - LogW'(1);
        end
        if (pv_q) begin
          ram_we    = 1'b1;
          ram_waddr = phys(head_q, pidx_q + LogW'(1));
          ram_wdata = ram_rdata;
          if (pidx_q == pos_q) begin
            state_d = SPut;
          end
        end
      end

      SPut: begin
        ram_we    = 1'b1;
        ram_waddr = phys(head_q, pos_q);
        ram_wdata = '{ts: ts_q, play: play_q, cnt: 8'd1};
        occ_d     = occ_q + LogW'(1);
        status_d  = StNew;
        done_d    = 1'b1;
        state_d   = SIdle;
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      head_q     <= '0;
      occ_q      <= '0;
      late_cnt_q <= '0;
      iss_act_q  <= 1'b0;
      pv_q       <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      occ_q      <= occ_d;
      late_cnt_q <= late_cnt_d;
      iss_act_q  <= iss_act_d;
      pv_q       <= pv_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ts_q      <= ts_d;
    play_q    <= play_d;
    now_q     <= now_d;
    wrapped_q <= wrapped_d;
    iss_q     <= iss_d;
    pidx_q    <= pidx_d;
    match_q   <= match_d;
    midx_q    <= midx_d;
    mdata_q   <= mdata_d;
    found_q   <= found_d;
    pos_q     <= pos_d;
    status_q  <= status_d;
    late_ms_q <= late_ms_d;
    ots_q     <= ots_d;
    oplay_q   <= oplay_d;
    ocnt_q    <= ocnt_d;
  end

  rtpq_ram #(
    .Width(EntryW),
    .Words(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rword)
  );

  assign busy_o             = (state_q != SIdle);
  assign done_o             = done_q;
  assign status_o           = status_q;
  assign late_ms_o          = late_ms_q;
  assign out_timestamp_o    = ots_q;
  assign out_playout_ms_o   = oplay_q;
  assign out_packet_count_o = ocnt_q;
  assign late_total_o       = late_cnt_q;

endmodule
